/* src/adsr_pkg.sv */
// shared types and constants of the adsr envelope amplitude block
package adsr_pkg;

   localparam int SAMPLE_RATE_HZ = 44100;

   localparam int TIME_W  = 24;
   localparam int LEVEL_W = 16;
   localparam int COUNT_W = 32;
   localparam int NUMER_W = LEVEL_W + TIME_W;
   localparam int DIV_STAGES = LEVEL_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = TIME_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTACK  = 3'd0,
      CSR_DECAY   = 3'd1,
      CSR_RELEASE = 3'd2,
      CSR_START   = 3'd3,
      CSR_SUSTAIN = 3'd4,
      CSR_FLOOR   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      NOTE_IDLE = 2'd0,
      NOTE_ON   = 2'd1,
      NOTE_OFF  = 2'd2
   } note_state_type;

   typedef enum logic [1:0] {
      SEG_ATTACK  = 2'd0,
      SEG_DECAY   = 2'd1,
      SEG_SUSTAIN = 2'd2
   } segment_type;

   localparam logic [TIME_W-1:0]  RST_ATTACK  = 24'd4410;
   localparam logic [TIME_W-1:0]  RST_DECAY   = 24'd26460;
   localparam logic [TIME_W-1:0]  RST_RELEASE = 24'd13230;
   localparam logic [LEVEL_W-1:0] RST_START   = 16'd32768;
   localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd32768;
   localparam logic [LEVEL_W-1:0] RST_FLOOR   = 16'd33;

endpackage

/* src/adsr_div.sv */
// pipelined restoring divider, one quotient bit per stage
module adsr_div (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [adsr_pkg::NUMER_W-1:0]  numer,
   input  logic [adsr_pkg::TIME_W-1:0]   divisor,
   output logic [adsr_pkg::LEVEL_W-1:0]  quotient
);
   import adsr_pkg::*;

   logic [NUMER_W-1:0] rem_ff [DIV_STAGES];
   logic [TIME_W-1:0]  dv_ff  [DIV_STAGES];
   logic [LEVEL_W-1:0] q_ff   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int BIT = DIV_STAGES - 1 - k;
      logic [NUMER_W-1:0] rem_src;
      logic [TIME_W-1:0]  dv_src;
      logic [LEVEL_W-1:0] q_src;
      logic [NUMER_W-1:0] shifted;
      logic [NUMER_W-1:0] rem_in;
      logic [LEVEL_W-1:0] q_in;

      if (k == 0) begin : g_first
         assign rem_src = numer;
         assign dv_src  = divisor;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign dv_src  = dv_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      assign shifted = {{LEVEL_W{1'b0}}, dv_src} << BIT;

      always_comb begin
         rem_in = rem_src;
         q_in   = q_src;
         if (rem_src >= shifted) begin
            rem_in    = rem_src - shifted;
            q_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            dv_ff[k]  <= dv_src;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign quotient = q_ff[DIV_STAGES-1];

endmodule

/* src/adsr_envelope_amplitude.sv */
// top level of the linear adsr envelope amplitude pipeline
// one voice evaluation is taken per clock and one amplitude comes out per clock
// while the output is not stalled; each item passes through the input register, the
// segment decode register, the two 16-stage divider pipelines (adsr level division,
// then release division) with the release product register between them, and the
// output register.
// the whole pipe advances together whenever the output register is empty or
// being taken, so a stall on rsp_ holds every stage and req_tready.
// csr_ writes must only happen while no item is in flight.
module adsr_envelope_amplitude (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write port
   input  logic                               csr_we,
   input  logic [adsr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [adsr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [95:0]                        req_tdata,  // current_sample, on_sample, off_sample
   input  logic [1:0]                         req_tuser,  // note_state
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata   // amplitude
);
   import adsr_pkg::*;

   // configuration registers
   logic [TIME_W-1:0]  attack_ff, decay_ff, release_ff;
   logic [LEVEL_W-1:0] start_ff, sustain_ff, floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= RST_ATTACK;
         decay_ff   <= RST_DECAY;
         release_ff <= RST_RELEASE;
         start_ff   <= RST_START;
         sustain_ff <= RST_SUSTAIN;
         floor_ff   <= RST_FLOOR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ATTACK:  attack_ff  <= csr_wdata;
            CSR_DECAY:   decay_ff   <= csr_wdata;
            CSR_RELEASE: release_ff <= csr_wdata;
            CSR_START:   start_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_SUSTAIN: sustain_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_FLOOR:   floor_ff   <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // global advance: output register empty or its transfer completes
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 0: input register, ages
   logic               v0_ff;
   logic [1:0]         state0_ff;
   logic [COUNT_W-1:0] age0_ff, rel0_ff;

   logic [COUNT_W-1:0] cur_w, on_w, off_w;
   assign cur_w = req_tdata[31:0];
   assign on_w  = req_tdata[63:32];
   assign off_w = req_tdata[95:64];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state0_ff <= req_tuser;
         // note on ages from now, note off ages at release
         age0_ff   <= (req_tuser == NOTE_ON) ? (cur_w - on_w) : (off_w - on_w);
         rel0_ff   <= cur_w - off_w;
      end
   end

   // stage 1: segment decode and numerator product
   logic               v1_ff;
   logic [1:0]         state1_ff;
   segment_type        seg1_ff;
   logic               neg1_ff;
   logic [COUNT_W-1:0] rel1_ff;
   logic [NUMER_W-1:0] numer1_ff;
   logic [TIME_W-1:0]  dv1_ff;

   logic [TIME_W:0]    ad_sum;
   logic [TIME_W-1:0]  elapsed;
   logic [LEVEL_W:0]   diff;
   logic [LEVEL_W-1:0] diff_mag;
   segment_type        seg_in;
   logic [NUMER_W-1:0] numer_in;
   logic [TIME_W-1:0]  dv_in;

   assign ad_sum   = {1'b0, attack_ff} + {1'b0, decay_ff};
   assign elapsed  = age0_ff[TIME_W-1:0] - attack_ff;
   assign diff     = {1'b0, start_ff} - {1'b0, sustain_ff};
   assign diff_mag = diff[LEVEL_W] ? (sustain_ff - start_ff) : diff[LEVEL_W-1:0];

   always_comb begin
      if (age0_ff < {{(COUNT_W-TIME_W){1'b0}}, attack_ff}) begin
         seg_in   = SEG_ATTACK;
         numer_in = start_ff * age0_ff[TIME_W-1:0];
         dv_in    = attack_ff;
      end else if (age0_ff < {{(COUNT_W-TIME_W-1){1'b0}}, ad_sum}) begin
         seg_in   = SEG_DECAY;
         numer_in = diff_mag * elapsed;
         dv_in    = decay_ff;
      end else begin
         seg_in   = SEG_SUSTAIN;
         numer_in = '0;
         dv_in    = decay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state1_ff <= state0_ff;
         seg1_ff   <= seg_in;
         neg1_ff   <= diff[LEVEL_W];
         rel1_ff   <= rel0_ff;
         numer1_ff <= numer_in;
         dv1_ff    <= dv_in;
      end
   end

   // first divider and its sideband
   logic [LEVEL_W-1:0] q1;
   adsr_div u_div_ads (
      .clock    (clock),
      .enable   (advance),
      .numer    (numer1_ff),
      .divisor  (dv1_ff),
      .quotient (q1)
   );

   logic               va_ff     [DIV_STAGES];
   logic [1:0]         statea_ff [DIV_STAGES];
   segment_type        sega_ff   [DIV_STAGES];
   logic               nega_ff   [DIV_STAGES];
   logic [COUNT_W-1:0] rela_ff   [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) va_ff[k] <= 1'b0;
      end else if (advance) begin
         va_ff[0] <= v1_ff;
         for (int k = 1; k < DIV_STAGES; k++) va_ff[k] <= va_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         statea_ff[0] <= state1_ff;
         sega_ff[0]   <= seg1_ff;
         nega_ff[0]   <= neg1_ff;
         rela_ff[0]   <= rel1_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            statea_ff[k] <= statea_ff[k-1];
            sega_ff[k]   <= sega_ff[k-1];
            nega_ff[k]   <= nega_ff[k-1];
            rela_ff[k]   <= rela_ff[k-1];
         end
      end
   end

   // stage 2: envelope level, release product
   localparam int LA = DIV_STAGES - 1;
   logic               v2_ff;
   logic [1:0]         state2_ff;
   logic [LEVEL_W-1:0] level2_ff;
   logic               inrel2_ff;
   logic [NUMER_W-1:0] numer2_ff;

   logic [LEVEL_W-1:0] level_in;
   logic               inrel_in;

   always_comb begin
      case (sega_ff[LA])
         SEG_ATTACK: level_in = q1;
         SEG_DECAY:  level_in = nega_ff[LA] ? (start_ff + q1) : (start_ff - q1);
         default:    level_in = sustain_ff;
      endcase
   end

   assign inrel_in = rela_ff[LA] < {{(COUNT_W-TIME_W){1'b0}}, release_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= va_ff[LA];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state2_ff <= statea_ff[LA];
         level2_ff <= level_in;
         inrel2_ff <= inrel_in;
         numer2_ff <= level_in * rela_ff[LA][TIME_W-1:0];
      end
   end

   // second divider for the release drop
   logic [LEVEL_W-1:0] q2;
   adsr_div u_div_rel (
      .clock    (clock),
      .enable   (advance),
      .numer    (numer2_ff),
      .divisor  (release_ff),
      .quotient (q2)
   );

   logic               vb_ff     [DIV_STAGES];
   logic [1:0]         stateb_ff [DIV_STAGES];
   logic [LEVEL_W-1:0] levelb_ff [DIV_STAGES];
   logic               inrelb_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) vb_ff[k] <= 1'b0;
      end else if (advance) begin
         vb_ff[0] <= v2_ff;
         for (int k = 1; k < DIV_STAGES; k++) vb_ff[k] <= vb_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stateb_ff[0] <= state2_ff;
         levelb_ff[0] <= level2_ff;
         inrelb_ff[0] <= inrel2_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            stateb_ff[k] <= stateb_ff[k-1];
            levelb_ff[k] <= levelb_ff[k-1];
            inrelb_ff[k] <= inrelb_ff[k-1];
         end
      end
   end

   // final stage: pick by note state, apply floor, output register
   logic [LEVEL_W-1:0] amp_in;
   logic [LEVEL_W-1:0] amp_ff;
   logic               out_valid_ff;

   always_comb begin
      case (stateb_ff[LA])
         NOTE_ON:  amp_in = levelb_ff[LA];
         NOTE_OFF: amp_in = inrelb_ff[LA] ? (levelb_ff[LA] - q2) : '0;
         default:  amp_in = '0;
      endcase
      if (amp_in < floor_ff) amp_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vb_ff[LA];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         amp_ff <= amp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = amp_ff;

endmodule

/* tb/testbench.sv */
// self-checking testbench of the adsr envelope amplitude pipeline
`timescale 1ns / 1ps

class amplitude_scoreboard;
   logic [23:0] attack_len, decay_len, release_len;
   logic [15:0] start_lvl, sustain_lvl, floor_lvl;
   logic [15:0] amp_queue[$];
   int errors;
   int checked;

   function new();
      errors = 0;
      checked = 0;
      attack_len = adsr_pkg::RST_ATTACK;
      decay_len = adsr_pkg::RST_DECAY;
      release_len = adsr_pkg::RST_RELEASE;
      start_lvl = adsr_pkg::RST_START;
      sustain_lvl = adsr_pkg::RST_SUSTAIN;
      floor_lvl = adsr_pkg::RST_FLOOR;
   endfunction

   function void set_register(adsr_pkg::csr_index_type idx, logic [23:0] val);
      case (idx)
         adsr_pkg::CSR_ATTACK:  attack_len = val;
         adsr_pkg::CSR_DECAY:   decay_len = val;
         adsr_pkg::CSR_RELEASE: release_len = val;
         adsr_pkg::CSR_START:   start_lvl = val[15:0];
         adsr_pkg::CSR_SUSTAIN: sustain_lvl = val[15:0];
         adsr_pkg::CSR_FLOOR:   floor_lvl = val[15:0];
         default: ;
      endcase
   endfunction

   // attack / decay / sustain curve at a given envelope age
   function longint unsigned curve_level(logic [31:0] age);
      longint signed diff, q;
      if (age < attack_len) return (longint'(start_lvl) * age) / attack_len;
      if (longint'(age) < longint'(attack_len) + longint'(decay_len)) begin
         diff = longint'(start_lvl) - longint'(sustain_lvl);
         q = (diff * (longint'(age) - longint'(attack_len))) / longint'(decay_len);
         return longint'(start_lvl) - q;
      end
      return sustain_lvl;
   endfunction

   function void note_request(logic [1:0] state, logic [31:0] cur, logic [31:0] on_s,
                              logic [31:0] off_s);
      longint unsigned amp, lvl, dt;
      amp = 0;
      if (state == adsr_pkg::NOTE_ON) begin
         amp = curve_level(cur - on_s);
      end else if (state == adsr_pkg::NOTE_OFF) begin
         lvl = curve_level(off_s - on_s);
         dt = 32'(cur - off_s);
         if (release_len != 0 && dt < release_len) amp = lvl - (lvl * dt) / release_len;
      end
      if (amp < floor_lvl) amp = 0;
      amp_queue.push_back(amp[15:0]);
   endfunction

   function void check_amplitude(logic [15:0] got);
      logic [15:0] want;
      if (amp_queue.size() == 0) begin
         $display("%0t: unexpected amplitude transfer, actual %0d", $time, got);
         errors++;
         return;
      end
      want = amp_queue.pop_front();
      checked++;
      if (got !== want) begin
         $display("%0t: amplitude mismatch, expected %0d actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module testbench;
   import adsr_pkg::*;

   localparam int LATENCY = 2 * LEVEL_W + 4;
   localparam longint CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // current_sample, on_sample, off_sample
   logic [1:0]  req_tuser = '0;   // note_state
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;        // amplitude

   amplitude_scoreboard sb = new();
   longint cycles = 0;
   bit quiet = 0;            // no idling in the last part of the run
   int directed_items = 0;
   int random_items = 0;

   adsr_envelope_amplitude dut (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver with random stall bursts
   initial begin
      int stall;
      @(posedge clock iff !reset);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
      end
   end

   // score every response transfer
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_amplitude(rsp_tdata);

   // one register write, then the write enable drops before the task returns
   task automatic write_reg(csr_index_type idx, logic [23:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      sb.set_register(idx, val);
      @(posedge clock);
   endtask

   // wait until the pipe is empty before touching registers
   task automatic drain();
      wait (sb.amp_queue.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // one request transfer, with an optional idle burst first
   task automatic send_note(logic [1:0] state, logic [31:0] cur, logic [31:0] on_s,
                            logic [31:0] off_s);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= state;
      req_tdata <= {off_s, on_s, cur};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(state, cur, on_s, off_s);
   endtask

   task automatic finish_burst();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // note ages spread across attack, decay, sustain and release
   task automatic random_note();
      logic [1:0] st;
      logic [31:0] on_s, off_s, cur;
      int span;
      span = sb.attack_len + sb.decay_len + sb.release_len + 64;
      st = $urandom_range(0, 9) == 0 ? 2'($urandom_range(0, 3))
                                     : ($urandom_range(0, 1) ? NOTE_ON : NOTE_OFF);
      on_s = $urandom();
      if ($urandom_range(0, 9) == 0) begin
         off_s = $urandom();
         cur = $urandom();
      end else begin
         off_s = on_s + $urandom_range(0, span);
         cur = (st == NOTE_OFF ? off_s : on_s) + $urandom_range(0, span);
      end
      send_note(st, cur, on_s, off_s);
   endtask

   task automatic random_phase(int n);
      repeat (n) random_note();
      finish_burst();
      random_items += n;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings, every note state and field extremes
      send_note(NOTE_IDLE, 32'd100, 32'd0, 32'd0);
      send_note(2'd3, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd0, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd2205, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd4409, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd20000, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd5, 32'hFFFF_FFFF, 32'd0);           // age wraps
      send_note(NOTE_ON, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);   // deep sustain
      send_note(NOTE_OFF, 32'd1000, 32'd0, 32'd1000);
      send_note(NOTE_OFF, 32'd8000, 32'd0, 32'd1000);
      send_note(NOTE_OFF, 32'd14229, 32'd0, 32'd1000);          // last sample of release
      send_note(NOTE_OFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // off wraps
      send_note(NOTE_OFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      finish_burst();
      directed_items = 13;

      // sender holds off until the pipe is empty
      drain();

      // decay toward a higher sustain (negative slope term) with the floor at zero
      write_reg(CSR_ATTACK, 24'd1);
      write_reg(CSR_DECAY, 24'd1);
      write_reg(CSR_RELEASE, 24'd1);
      write_reg(CSR_START, 24'd0);
      write_reg(CSR_SUSTAIN, 24'h00FFFF);
      write_reg(CSR_FLOOR, 24'd0);
      write_reg(csr_index_type'(3'd7), 24'hFFFFFF);   // ignored index
      send_note(NOTE_ON, 32'd0, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd1, 32'd0, 32'd0);
      send_note(NOTE_ON, 32'd2, 32'd0, 32'd0);
      send_note(NOTE_OFF, 32'd5, 32'd0, 32'd5);
      send_note(NOTE_OFF, 32'd6, 32'd0, 32'd5);
      finish_burst();
      directed_items += 5;
      random_phase(300);
      drain();

      // widest times and levels
      write_reg(CSR_ATTACK, 24'hFFFFFF);
      write_reg(CSR_DECAY, 24'hFFFFFF);
      write_reg(CSR_RELEASE, 24'hFFFFFF);
      write_reg(CSR_START, 24'h00FFFF);
      write_reg(CSR_SUSTAIN, 24'd0);
      write_reg(CSR_FLOOR, 24'h00FFFF);
      random_phase(300);
      drain();

      write_reg(CSR_FLOOR, 24'd0);
      random_phase(300);
      drain();

      // random mid-range settings
      repeat (3) begin
         write_reg(CSR_ATTACK, 24'($urandom_range(1, 5000)));
         write_reg(CSR_DECAY, 24'($urandom_range(1, 5000)));
         write_reg(CSR_RELEASE, 24'($urandom_range(1, 5000)));
         write_reg(CSR_START, 24'($urandom_range(0, 65535)));
         write_reg(CSR_SUSTAIN, 24'($urandom_range(0, 65535)));
         write_reg(CSR_FLOOR, 24'($urandom_range(0, 2000)));
         random_phase(300);
         drain();
      end

      // last stretch without idling on either side
      quiet = 1;
      random_phase(200);

      wait (sb.amp_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d directed and %0d random notes over seven register settings",
               directed_items, random_items);
      $display("%0d amplitudes checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.amp_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
